// ===== rtl/dtls_pkg.sv =====
// types and constants shared by the dtls record header parser
package dtls_pkg;

   localparam logic [15:0] VERSION_LEGACY = 16'h0100;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_PREFIX   = 3'd1,
      PH_SID_LEN  = 3'd2,
      PH_SID_SKIP = 3'd3,
      PH_CK_LEN   = 3'd4,
      PH_CK_SKIP  = 3'd5,
      PH_CS_LEN   = 3'd6,
      PH_SUITES   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] suite_value;
      logic [5:0]  suite_index;
      logic        is_dtls;
      logic [7:0]  record_type_out;
      logic [15:0] record_version_out;
      logic [15:0] record_epoch_out;
      logic [47:0] record_sequence_out;
      logic [15:0] record_length_out;
      logic        suites_ok;
      logic [14:0] suites_declared;
      logic        last;
   } rsp_type;

   // what the front part hands to the back part for one byte
   typedef struct packed {
      logic    suite_valid;
      rsp_type suite;
      logic    summary_valid;
      rsp_type summary;
   } work_type;

endpackage

// ===== rtl/dtls_front.sv =====
// byte parser: tracks position and phase, builds suite entries and summaries
module dtls_front #(
   parameter int MAX_SUITES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept_legacy,
   input  logic             in_valid,
   input  dtls_pkg::req_type in_item,
   output dtls_pkg::work_type work
);
   import dtls_pkg::*;

   localparam logic [14:0] LIMIT = 15'(MAX_SUITES);

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] ver_ff, ver_in;
   logic [15:0] epoch_ff, epoch_in;
   logic [47:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  skip_ff, skip_in;
   logic [14:0] decl_ff, decl_in;
   logic [6:0]  seen_ff, seen_in;
   logic [7:0]  high_ff, high_in;
   logic        fail_ff, fail_in;

   logic [7:0]  b;
   logic [14:0] limit_cur, limit_new;
   logic        ver_ok;

   function automatic logic vok(input logic [15:0] v, input logic leg);
      return v == 16'hFEFF || v == 16'hFEFD || v == 16'hFEFC
         || (v == VERSION_LEGACY && leg);
   endfunction

   always_comb begin
      b = in_item.data_byte;
      pos_in = pos_ff; type_in = type_ff; ver_in = ver_ff; epoch_in = epoch_ff;
      seq_in = seq_ff; len_in = len_ff; phase_in = phase_ff; skip_in = skip_ff;
      decl_in = decl_ff; seen_in = seen_ff; high_in = high_ff; fail_in = fail_ff;
      work = '0;
      limit_cur = (decl_ff < LIMIT) ? decl_ff : LIMIT;
      if (pos_ff <= 16'd12) begin
         if (pos_ff == 16'd0) type_in = b;
         else if (pos_ff <= 16'd2) ver_in = {ver_ff[7:0], b};
         else if (pos_ff <= 16'd4) epoch_in = {epoch_ff[7:0], b};
         else if (pos_ff <= 16'd10) seq_in = {seq_ff[39:0], b};
         else len_in = {len_ff[7:0], b};
         if (pos_ff == 16'd12) begin
            if (type_ff == 8'd22 && vok(ver_ff, accept_legacy)) phase_in = PH_PREFIX;
            else fail_in = 1'b1;
         end
      end else if (!fail_ff) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (pos_ff == 16'd13 && b != 8'd1) fail_in = 1'b1;
               if (pos_ff == 16'd58) phase_in = PH_SID_LEN;
            end
            PH_SID_LEN, PH_CK_LEN: begin
               skip_in = b;
               phase_in = (b != 8'd0) ? phase_type'(phase_ff + 3'd1)
                                      : phase_type'(phase_ff + 3'd2);
            end
            PH_SID_SKIP, PH_CK_SKIP: begin
               skip_in = skip_ff - 8'd1;
               if (skip_in == 8'd0) phase_in = phase_type'(phase_ff + 3'd1);
            end
            PH_CS_LEN: begin
               if (skip_ff == 8'd0) begin
                  high_in = b; skip_in = 8'd1;
               end else begin
                  decl_in = {high_ff, b[7:1]};
                  skip_in = 8'd0;
                  phase_in = PH_SUITES;
               end
            end
            PH_SUITES: begin
               if ({8'd0, seen_ff} < {1'b0, limit_cur}) begin
                  if (skip_ff == 8'd0) begin
                     high_in = b; skip_in = 8'd1;
                  end else begin
                     work.suite_valid = in_valid;
                     work.suite.suite_value = {high_ff, b};
                     work.suite.suite_index = seen_ff[5:0];
                     seen_in = seen_ff + 7'd1;
                     skip_in = 8'd0;
                  end
               end
            end
            default: ;
         endcase
      end
      if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
      limit_new = (decl_in < LIMIT) ? decl_in : LIMIT;
      ver_ok = vok(ver_in, accept_legacy);
      work.summary.result_kind = 1'b1;
      work.summary.is_dtls = pos_in > 16'd13 && type_in >= 8'd20 && type_in <= 8'd24
         && ver_ok;
      work.summary.record_type_out = type_in;
      work.summary.record_version_out = ver_in;
      work.summary.record_epoch_out = epoch_in;
      work.summary.record_sequence_out = seq_in;
      work.summary.record_length_out = len_in;
      work.summary.suites_ok = !fail_in && phase_in == PH_SUITES
         && {8'd0, seen_in} >= {1'b0, limit_new};
      work.summary.suites_declared = decl_in;
      work.summary.last = 1'b1;
      work.summary_valid = in_valid && in_item.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || (in_valid && in_item.last_byte)) begin
         pos_ff <= '0; type_ff <= '0; ver_ff <= '0; epoch_ff <= '0; seq_ff <= '0;
         len_ff <= '0; phase_ff <= PH_HEADER; skip_ff <= '0; decl_ff <= '0;
         seen_ff <= '0; high_ff <= '0; fail_ff <= 1'b0;
      end else if (in_valid) begin
         pos_ff <= pos_in; type_ff <= type_in; ver_ff <= ver_in; epoch_ff <= epoch_in;
         seq_ff <= seq_in; len_ff <= len_in; phase_ff <= phase_in; skip_ff <= skip_in;
         decl_ff <= decl_in; seen_ff <= seen_in; high_ff <= high_in; fail_ff <= fail_in;
      end
   end
endmodule

// ===== rtl/dtls_queue.sv =====
// result queue: takes up to two results per cycle, delivers one per pop
module dtls_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  dtls_pkg::work_type work,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output dtls_pkg::rsp_type  head
);
   import dtls_pkg::*;

   localparam int AW = $clog2(DEPTH);

   rsp_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            do_pop;

   assign empty = cnt_ff == '0;
   assign full = cnt_ff > (AW+1)'(DEPTH - 2);
   assign head = mem_ff[rd_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = wr_ff;
      cnt_in = cnt_ff;
      if (work.suite_valid) wr_in = wr_in + 1'b1;
      if (work.summary_valid) wr_in = wr_in + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(work.suite_valid) + (AW+1)'(work.summary_valid)
         - (AW+1)'(do_pop);
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (work.suite_valid) mem_ff[wr_ff] <= work.suite;
      if (work.summary_valid) begin
         if (work.suite_valid) mem_ff[wr_ff + 1'b1] <= work.summary;
         else mem_ff[wr_ff] <= work.summary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== rtl/dtls_record_header_parser.sv =====
// top level of the dtls record header and client hello suite parser
// One payload byte is taken per cycle while full is low; the parser keeps a byte
// counter and phase and emits up to two results per byte (a suite entry and,
// on the last byte, a packet summary) into a four-entry result queue. full
// rises when fewer than two free slots remain, so input stalls only when the
// consumer falls behind. Each result is written into the queue on the clock edge that takes its byte.
module dtls_record_header_parser #(
   parameter int MAX_SUITES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  dtls_pkg::req_type  req_item,
   output logic              empty,
   input  logic              pop,
   output dtls_pkg::rsp_type  rsp_item,
   input  logic              csr_write,
   input  logic              csr_data
);
   import dtls_pkg::*;

   logic     legacy_ff;
   work_type work;

   always_ff @(posedge clock) begin
      if (reset) legacy_ff <= 1'b1;
      else if (csr_write) legacy_ff <= csr_data;
   end

   dtls_front #(.MAX_SUITES(MAX_SUITES)) u_front (
      .clock(clock), .reset(reset), .accept_legacy(legacy_ff),
      .in_valid(push && !full), .in_item(req_item), .work(work)
   );

   dtls_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset), .work(work), .full(full),
      .empty(empty), .pop(pop), .head(rsp_item)
   );
endmodule

// ===== tb/dtls_record_header_parser_tb.sv =====
// self-checking testbench for the dtls record header and client hello suite parser
`timescale 1ns / 1ps

module dtls_record_header_parser_tb;
   import dtls_pkg::*;

   localparam int SUITE_CAP = 64;
   localparam int STALL_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;
   logic    csr_write;
   logic    csr_data;

   dtls_record_header_parser #(.MAX_SUITES(SUITE_CAP)) dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   req_type   byte_q[$];
   rsp_type   result_q[$];
   logic [7:0] pkt[$];
   int        errors = 0;
   int        bytes_in = 0;
   int        idle_cycles = 0;
   bit        calm = 0;

   // parser state mirror
   bit         legacy_en;
   logic [15:0] pos;
   logic [7:0]  rec_type;
   logic [15:0] rec_ver;
   logic [15:0] rec_epoch;
   logic [47:0] rec_seq;
   logic [15:0] rec_len;
   logic [7:0]  hs_kind;
   phase_type   phase;
   logic [7:0]  skip;
   logic [14:0] declared;
   logic [6:0]  seen;
   logic [7:0]  hi_byte;
   bit          bad;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void clear_stream();
      pos = '0; rec_type = '0; rec_ver = '0; rec_epoch = '0; rec_seq = '0; rec_len = '0;
      hs_kind = '0; phase = PH_HEADER; skip = '0; declared = '0; seen = '0;
      hi_byte = '0; bad = 0;
   endfunction

   function automatic bit version_accepted(logic [15:0] v);
      return v == 16'hFEFF || v == 16'hFEFD || v == 16'hFEFC ||
             (v == VERSION_LEGACY && legacy_en);
   endfunction

   function automatic int suite_bound();
      return declared < SUITE_CAP ? int'(declared) : SUITE_CAP;
   endfunction

   function automatic void parse_byte(req_type r);
      rsp_type     e;
      logic [7:0]  b;
      logic [15:0] w;
      b = r.data_byte;
      if (pos <= 12) begin
         if (pos == 0) rec_type = b;
         else if (pos <= 2) rec_ver = {rec_ver[7:0], b};
         else if (pos <= 4) rec_epoch = {rec_epoch[7:0], b};
         else if (pos <= 10) rec_seq = {rec_seq[39:0], b};
         else rec_len = {rec_len[7:0], b};
         if (pos == 12) begin
            if (rec_type == 8'd22 && version_accepted(rec_ver)) phase = PH_PREFIX;
            else bad = 1;
         end
      end else if (!bad) begin
         case (phase)
            PH_PREFIX: begin
               if (pos == 13) begin
                  hs_kind = b;
                  if (b != 8'd1) bad = 1;
               end
               if (pos == 58) phase = PH_SID_LEN;
            end
            PH_SID_LEN, PH_CK_LEN: begin
               skip = b;
               phase = phase_type'(phase + ((b != 0) ? 3'd1 : 3'd2));
            end
            PH_SID_SKIP, PH_CK_SKIP: begin
               skip = skip - 8'd1;
               if (skip == 0) phase = phase_type'(phase + 3'd1);
            end
            PH_CS_LEN: begin
               if (skip == 0) begin
                  hi_byte = b;
                  skip = 8'd1;
               end else begin
                  w = {hi_byte, b};
                  declared = w[15:1];
                  skip = 8'd0;
                  phase = PH_SUITES;
               end
            end
            PH_SUITES: begin
               if (int'(seen) < suite_bound()) begin
                  if (skip == 0) begin
                     hi_byte = b;
                     skip = 8'd1;
                  end else begin
                     e = '0;
                     e.suite_value = {hi_byte, b};
                     e.suite_index = seen[5:0];
                     result_q.push_back(e);
                     seen = seen + 7'd1;
                     skip = 8'd0;
                  end
               end
            end
            default: ;
         endcase
      end
      if (pos != 16'hFFFF) pos = pos + 16'd1;
      if (r.last_byte) begin
         e = '0;
         e.result_kind = 1'b1;
         e.is_dtls = pos > 13 && rec_type >= 20 && rec_type <= 24 && version_accepted(rec_ver);
         e.record_type_out = rec_type;
         e.record_version_out = rec_ver;
         e.record_epoch_out = rec_epoch;
         e.record_sequence_out = rec_seq;
         e.record_length_out = rec_len;
         e.suites_ok = !bad && phase == PH_SUITES && int'(seen) >= suite_bound();
         e.suites_declared = declared;
         e.last = 1'b1;
         result_q.push_back(e);
         clear_stream();
      end
   endfunction

   // driver
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            parse_byte(req_item);
            bytes_in++;
         end
         if (!(push && full)) begin
            if (tx_gap == 0 && !calm && $urandom_range(0, 15) == 0)
               tx_gap = $urandom_range(1, 9);
            if (tx_gap > 0 || byte_q.size() == 0) begin
               push <= 1'b0;
               if (tx_gap > 0) tx_gap--;
            end else begin
               push <= 1'b1;
               req_item <= byte_q.pop_front();
            end
         end
      end
   end

   // monitor
   int  rx_gap = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (result_q.size() == 0) begin
               $error("unexpected transaction: %p", rsp_item);
               errors++;
            end else begin
               e = result_q.pop_front();
               if (rsp_item.result_kind !== e.result_kind) begin
                  $error("result_kind exp %0h got %0h", e.result_kind, rsp_item.result_kind);
                  errors++;
               end
               if (rsp_item.suite_value !== e.suite_value) begin
                  $error("suite_value exp %0h got %0h", e.suite_value, rsp_item.suite_value);
                  errors++;
               end
               if (rsp_item.suite_index !== e.suite_index) begin
                  $error("suite_index exp %0h got %0h", e.suite_index, rsp_item.suite_index);
                  errors++;
               end
               if (rsp_item.is_dtls !== e.is_dtls) begin
                  $error("is_dtls exp %0h got %0h", e.is_dtls, rsp_item.is_dtls);
                  errors++;
               end
               if (rsp_item.record_type_out !== e.record_type_out) begin
                  $error("record_type_out exp %0h got %0h", e.record_type_out,
                         rsp_item.record_type_out);
                  errors++;
               end
               if (rsp_item.record_version_out !== e.record_version_out) begin
                  $error("record_version_out exp %0h got %0h", e.record_version_out,
                         rsp_item.record_version_out);
                  errors++;
               end
               if (rsp_item.record_epoch_out !== e.record_epoch_out) begin
                  $error("record_epoch_out exp %0h got %0h", e.record_epoch_out,
                         rsp_item.record_epoch_out);
                  errors++;
               end
               if (rsp_item.record_sequence_out !== e.record_sequence_out) begin
                  $error("record_sequence_out exp %0h got %0h", e.record_sequence_out,
                         rsp_item.record_sequence_out);
                  errors++;
               end
               if (rsp_item.record_length_out !== e.record_length_out) begin
                  $error("record_length_out exp %0h got %0h", e.record_length_out,
                         rsp_item.record_length_out);
                  errors++;
               end
               if (rsp_item.suites_ok !== e.suites_ok) begin
                  $error("suites_ok exp %0h got %0h", e.suites_ok, rsp_item.suites_ok);
                  errors++;
               end
               if (rsp_item.suites_declared !== e.suites_declared) begin
                  $error("suites_declared exp %0h got %0h", e.suites_declared,
                         rsp_item.suites_declared);
                  errors++;
               end
               if (rsp_item.last !== e.last) begin
                  $error("last exp %0h got %0h", e.last, rsp_item.last);
                  errors++;
               end
            end
         end
         // long receiver hold so the result queue backs up into the input
         if (!long_hold_done && bytes_in >= 400) begin
            long_hold_done = 1;
            rx_gap = 300;
         end else if (rx_gap == 0 && !calm && $urandom_range(0, 15) == 0) begin
            rx_gap = $urandom_range(1, 9);
         end
         if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset || csr_write) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("dtls_record_header_parser regression: fail");
         $finish;
      end
   end

   task automatic flush_packet(input int cut);
      int n;
      n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
      for (int i = 0; i < n; i++)
         byte_q.push_back(req_type'{data_byte: pkt[i], last_byte: i == n - 1});
      pkt.delete();
   endtask

   task automatic put_header(input logic [7:0] t, input logic [15:0] ver);
      logic [47:0] sq;
      sq = {$urandom, $urandom};
      pkt.push_back(t);
      pkt.push_back(ver[15:8]);
      pkt.push_back(ver[7:0]);
      pkt.push_back($urandom);
      pkt.push_back($urandom);
      for (int i = 5; i >= 0; i--) pkt.push_back(sq[i*8 +: 8]);
      pkt.push_back($urandom);
      pkt.push_back($urandom);
   endtask

   task automatic client_hello(input logic [15:0] ver, input logic [7:0] kind, input int sid,
                               input int ck, input logic [15:0] cslen, input int sbytes,
                               input int cut);
      put_header(8'd22, ver);
      pkt.push_back(kind);
      repeat (45) pkt.push_back($urandom);
      pkt.push_back(sid[7:0]);
      repeat (sid) pkt.push_back($urandom);
      pkt.push_back(ck[7:0]);
      repeat (ck) pkt.push_back($urandom);
      pkt.push_back(cslen[15:8]);
      pkt.push_back(cslen[7:0]);
      repeat (sbytes) pkt.push_back($urandom);
      flush_packet(cut);
   endtask

   task automatic noise_packet(input int n);
      logic [15:0] vers[4] = '{16'hFEFF, 16'hFEFD, 16'hFEFC, VERSION_LEGACY};
      if ($urandom_range(0, 1)) put_header($urandom_range(18, 26), vers[$urandom_range(0, 3)]);
      repeat (n) pkt.push_back($urandom);
      flush_packet(0);
   endtask

   task automatic random_traffic(input int count);
      logic [15:0] vers[5] = '{16'hFEFF, 16'hFEFD, 16'hFEFC, VERSION_LEGACY, 16'hFEFE};
      int          target, k, cs;
      target = byte_q.size() + count;
      while (byte_q.size() < target) begin
         k = $urandom_range(0, 19);
         cs = $urandom_range(0, 8) * 2 + (($urandom_range(0, 7) == 0) ? 1 : 0);
         if (k < 14)
            client_hello(vers[$urandom_range(0, 4)], ($urandom_range(0, 9) == 0) ? $urandom : 1,
                         $urandom_range(0, 6), $urandom_range(0, 6), cs,
                         cs + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 0), 0);
         else if (k < 16)
            client_hello(vers[$urandom_range(0, 3)], 1, $urandom_range(0, 4),
                         $urandom_range(0, 4), cs, cs, $urandom_range(1, 75));
         else
            noise_packet($urandom_range(0, 20));
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (byte_q.size() != 0 || push || result_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_legacy(input bit v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= v;
      legacy_en = v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_item = '0;
      csr_write = 1'b0;
      csr_data = 1'b0;
      legacy_en = 1;
      clear_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed packets
      byte_q.push_back(req_type'{data_byte: 8'hFF, last_byte: 1'b1});
      pkt.push_back(8'h00); pkt.push_back(8'h00); flush_packet(0);
      put_header(8'd22, 16'hFEFD); flush_packet(0);
      put_header(8'd22, 16'hFEFD); pkt.push_back(8'd1); flush_packet(0);
      put_header(8'd23, 16'hFEFF); repeat (7) pkt.push_back($urandom); flush_packet(0);
      put_header(8'd22, 16'h0303); repeat (5) pkt.push_back($urandom); flush_packet(0);
      client_hello(16'hFEFD, 1, 0, 0, 0, 0, 0);
      client_hello(16'hFEFC, 1, 1, 1, 5, 6, 0);
      client_hello(VERSION_LEGACY, 1, 2, 0, 4, 4, 0);
      client_hello(16'hFEFD, 2, 0, 0, 4, 4, 0);
      client_hello(16'hFEFD, 1, 12, 12, 16'hFFFF, 130, 0);
      client_hello(16'hFEFD, 1, 0, 0, 10, 10, 66);
      wait_drained();

      set_legacy(0);
      client_hello(VERSION_LEGACY, 1, 0, 0, 4, 4, 0);
      random_traffic(40);
      wait_drained();

      set_legacy(1);
      random_traffic(40);
      wait_drained();

      set_legacy(0);
      calm = 1;
      random_traffic(30);
      wait_drained();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("dtls_record_header_parser regression: pass");
      end else begin
         $display("dtls_record_header_parser regression: fail");
      end
      $finish;
   end

endmodule
